// ----- hdl/smo_pkg.sv -----
// Package for the servo motion observer: payload structs, per-servo record,
// motion class codes and classifier thresholds. Depends on nothing; imported
// by smo_motion_calc, servo_motion_observer_top, smo_checker and the testbench.
`default_nettype none

package smo_pkg;

   // Block sizing
   localparam int SERVO_COUNT    = 16;
   localparam int CENTER_DEFAULT = 1500;
   localparam int SERVO_IDX_W    = (SERVO_COUNT > 1) ? $clog2(SERVO_COUNT) : 1;

   // Field limits
   localparam logic [11:0] PULSE_MAX = 12'hFFF;
   localparam logic [7:0]  CONF_MAX  = 8'd255;

   // Classifier thresholds
   localparam logic [11:0] STILL_SPEED   = 12'd5;
   localparam logic [11:0] NEAR_CENTER   = 12'd30;
   localparam logic [11:0] ERRATIC_SPEED = 12'd100;
   localparam logic [12:0] DECEL_ACCEL   = 13'd50;
   localparam logic [11:0] DRIVE_SPEED   = 12'd20;
   localparam logic [11:0] OSC_SPEED_LO  = 12'd10;
   localparam logic [11:0] OSC_SPEED_HI  = 12'd40;
   localparam logic [12:0] OSC_ACCEL     = 13'd10;
   localparam logic [11:0] SMOOTH_SPEED  = 12'd15;

   typedef enum logic [2:0] {
      MC_STILL_OFF    = 3'd0,
      MC_SLOW         = 3'd1,
      MC_DRIVING      = 3'd2,
      MC_DECELERATING = 3'd3,
      MC_BALANCED     = 3'd4,
      MC_ERRATIC      = 3'd5,
      MC_SMOOTH       = 3'd6,
      MC_OSCILLATING  = 3'd7
   } motion_class_type;

   typedef struct packed {
      logic [7:0]  servo_index;
      logic [11:0] pulse_us;
   } req_type;

   typedef struct packed {
      logic [7:0]  servo_echo;
      logic [2:0]  motion_class;
      logic [11:0] speed_us;
      logic [11:0] learned_center;
      logic [11:0] lowest_seen;
      logic [11:0] highest_seen;
      logic [7:0]  sample_confidence;
   } rsp_type;

   typedef struct packed {
      logic [11:0] prev_pulse;
      logic [11:0] prev_speed;
      logic [11:0] center_avg;
      logic [11:0] min_track;
      logic [11:0] max_track;
      logic [7:0]  conf_count;
   } servo_rec_type;

   typedef struct packed {
      servo_rec_type rec;
      logic [11:0]   pulse;
   } calc_in_type;

   typedef struct packed {
      servo_rec_type    rec;
      motion_class_type cls;
   } calc_out_type;

   // Record of a servo that has never been sampled
   function automatic servo_rec_type rec_reset_value();
      servo_rec_type r;
      r.prev_pulse = 12'(CENTER_DEFAULT);
      r.prev_speed = '0;
      r.center_avg = 12'(CENTER_DEFAULT);
      r.min_track  = PULSE_MAX;
      r.max_track  = '0;
      r.conf_count = '0;
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- hdl/smo_motion_calc.sv -----
// Combinational update of one servo record: min/max, speed, acceleration,
// motion class, center average and confidence.
// Depends on smo_pkg.
`default_nettype none

module smo_motion_calc (
   input  smo_pkg::calc_in_type  calc_in,
   output smo_pkg::calc_out_type calc_out
);
   import smo_pkg::*;

   logic signed [12:0] vel;
   logic        [11:0] v;
   logic signed [13:0] acc;
   logic        [12:0] a;
   logic signed [12:0] dpos;
   logic        [11:0] d;
   logic        [14:0] a3_plus3;
   logic        [15:0] ctr_x15;
   motion_class_type   cls;

   // Velocity and its magnitude
   assign vel = $signed({1'b0, calc_in.pulse}) - $signed({1'b0, calc_in.rec.prev_pulse});
   assign v   = vel[12] ? 12'(-vel) : vel[11:0];

   // Acceleration against the stored speed magnitude
   assign acc = $signed({vel[12], vel}) - $signed({2'b00, calc_in.rec.prev_speed});
   assign a   = acc[13] ? 13'(-acc) : acc[12:0];

   // Distance from the center as it stood before this sample
   assign dpos = $signed({1'b0, calc_in.pulse}) - $signed({1'b0, calc_in.rec.center_avg});
   assign d    = dpos[12] ? 12'(-dpos) : dpos[11:0];

   // a < floor(v/3) holds exactly when 3a + 3 <= v
   assign a3_plus3 = 15'({2'b00, a}) + 15'({1'b0, a, 1'b0}) + 15'd3;

   // Pick the first rule that holds
   always_comb begin
      priority if (v < STILL_SPEED && d < NEAR_CENTER) begin
         cls = MC_BALANCED;
      end else if (v < STILL_SPEED) begin
         cls = MC_STILL_OFF;
      end else if (v > ERRATIC_SPEED) begin
         cls = MC_ERRATIC;
      end else if (a > DECEL_ACCEL && v > DRIVE_SPEED) begin
         cls = MC_DECELERATING;
      end else if (v > OSC_SPEED_LO && v < OSC_SPEED_HI && a > OSC_ACCEL) begin
         cls = MC_OSCILLATING;
      end else if (v > SMOOTH_SPEED && a3_plus3 <= {3'b000, v}) begin
         cls = MC_SMOOTH;
      end else if (v > DRIVE_SPEED) begin
         cls = MC_DRIVING;
      end else begin
         cls = MC_SLOW;
      end
   end

   // Center times fifteen, as shift and subtract
   assign ctr_x15 = {calc_in.rec.center_avg, 4'b0000} - {4'b0000, calc_in.rec.center_avg};

   // Build the updated record
   always_comb begin
      calc_out.cls            = cls;
      calc_out.rec.prev_pulse = calc_in.pulse;
      calc_out.rec.prev_speed = v;
      calc_out.rec.center_avg = ctr_x15[15:4] + {4'b0000, calc_in.pulse[11:4]};
      calc_out.rec.min_track  = (calc_in.pulse < calc_in.rec.min_track) ?
                                calc_in.pulse : calc_in.rec.min_track;
      calc_out.rec.max_track  = (calc_in.pulse > calc_in.rec.max_track) ?
                                calc_in.pulse : calc_in.rec.max_track;
      calc_out.rec.conf_count = (calc_in.rec.conf_count == CONF_MAX) ?
                                calc_in.rec.conf_count : calc_in.rec.conf_count + 8'd1;
   end

endmodule

`default_nettype wire

// ----- hdl/servo_motion_observer_top.sv -----
// Top level of the servo motion observer: record memory, update stage,
// result register. Depends on smo_pkg and smo_motion_calc.
//
//   channel | ports                       | beat
//   --------+-----------------------------+---------------------------------
//   request | req_valid req_ready req_data | servo_index, pulse_us
//   result  | rsp_valid rsp_ready rsp_data | one record update per sample
//
// One sample per cycle unless results stall; taking a beat reads its record,
// and the result register and rsp_valid load when the update stage advances.
// A sample for the servo just written is served from the last-write register.
// Reset is synchronous; per-entry valid bits make an unwritten record read as
// its reset value, so no clearing pass is needed.
// A stalled result holds the update stage, which in turn drops req_ready.
// Samples with servo_index at or above the servo count are taken and dropped.
`default_nettype none

module servo_motion_observer_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  smo_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output smo_pkg::rsp_type rsp_data
);
   import smo_pkg::*;

   servo_rec_type            rec_mem [SERVO_COUNT];
   servo_rec_type            mem_q_ff;
   logic                     rd_valid_ff;
   logic [SERVO_COUNT-1:0]   entry_valid_ff;

   logic                     s1_valid_ff;
   req_type                  s1_req_ff;
   logic                     lw_valid_ff;
   logic [SERVO_IDX_W-1:0]   lw_idx_ff;
   servo_rec_type            lw_rec_ff;

   logic                     rsp_valid_ff;
   rsp_type                  rsp_data_ff;

   logic                     req_take;
   logic                     in_range;
   logic                     s1_advance;
   logic [SERVO_IDX_W-1:0]   req_idx;
   logic [SERVO_IDX_W-1:0]   s1_idx;
   calc_in_type              calc_in;
   calc_out_type             calc_out;
   rsp_type                  rsp_in;

   // Handshake
   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || s1_advance;
   assign req_take   = req_valid && req_ready;
   assign in_range   = {1'b0, req_data.servo_index} < 9'(SERVO_COUNT);
   assign req_idx    = req_data.servo_index[SERVO_IDX_W-1:0];
   assign s1_idx     = s1_req_ff.servo_index[SERVO_IDX_W-1:0];

   // Read the record on each taken beat
   always_ff @(posedge clock) begin
      if (req_take) begin
         mem_q_ff    <= rec_mem[req_idx];
         rd_valid_ff <= entry_valid_ff[req_idx];
         s1_req_ff   <= req_data;
      end
   end

   // Write the updated record back
   always_ff @(posedge clock) begin
      if (s1_advance) begin
         rec_mem[s1_idx] <= calc_out.rec;
      end
   end

   // Select forwarded, stored or reset record
   always_comb begin
      priority if (lw_valid_ff && lw_idx_ff == s1_idx) begin
         calc_in.rec = lw_rec_ff;
      end else if (rd_valid_ff) begin
         calc_in.rec = mem_q_ff;
      end else begin
         calc_in.rec = rec_reset_value();
      end
      calc_in.pulse = s1_req_ff.pulse_us;
   end

   smo_motion_calc u_calc (
      .calc_in  (calc_in),
      .calc_out (calc_out)
   );

   // Form the result beat
   always_comb begin
      rsp_in.servo_echo        = s1_req_ff.servo_index;
      rsp_in.motion_class      = calc_out.cls;
      rsp_in.speed_us          = calc_out.rec.prev_speed;
      rsp_in.learned_center    = calc_out.rec.center_avg;
      rsp_in.lowest_seen       = calc_out.rec.min_track;
      rsp_in.highest_seen      = calc_out.rec.max_track;
      rsp_in.sample_confidence = calc_out.rec.conf_count;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         lw_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         entry_valid_ff <= '0;
      end else begin
         if (req_ready) begin
            s1_valid_ff <= req_take && in_range;
         end
         if (s1_advance) begin
            lw_valid_ff            <= 1'b1;
            entry_valid_ff[s1_idx] <= 1'b1;
         end
         if (s1_advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (s1_advance) begin
         lw_idx_ff   <= s1_idx;
         lw_rec_ff   <= calc_out.rec;
         rsp_data_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A dropped beat leaves the update stage empty
   a_drop_empty: assert property (@(posedge clock) disable iff (reset)
      req_take && !in_range |=> !s1_valid_ff)
      else $error("dropped sample entered the update stage");

   // Every write back produces a result beat
   a_write_result: assert property (@(posedge clock) disable iff (reset)
      s1_advance |=> rsp_valid_ff)
      else $error("record written without a result");

   // A held update stage keeps its sample
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_advance |=> s1_valid_ff && $stable(s1_req_ff))
      else $error("stalled sample lost or changed");

   // A result always has a non-empty tracked range and a nonzero confidence
   a_range_sane: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_data_ff.lowest_seen <= rsp_data_ff.highest_seen &&
                       rsp_data_ff.sample_confidence != 8'd0)
      else $error("result with empty tracked range");

endmodule

`default_nettype wire

// ----- tb/smo_checker.sv -----
// Checker for the servo motion observer: tracks every servo record on its own,
// predicts each result beat and compares it field by field with the block.
// Depends on smo_pkg; instantiated beside the block by servo_motion_observer_top_tb.
`default_nettype none

module smo_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  smo_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  smo_pkg::rsp_type rsp_data,
   output int unsigned      results_due,
   output int unsigned      failures
);
   timeunit 1ns;
   timeprecision 1ps;

   import smo_pkg::*;

   localparam int REPORT_LIMIT = 10;

   // Shadow copy of every servo record
   logic [11:0] shadow_pulse  [SERVO_COUNT];
   logic [11:0] shadow_speed  [SERVO_COUNT];
   logic [11:0] shadow_center [SERVO_COUNT];
   logic [11:0] shadow_low    [SERVO_COUNT];
   logic [11:0] shadow_high   [SERVO_COUNT];
   logic [7:0]  shadow_conf   [SERVO_COUNT];

   rsp_type pending_updates[$];

   function automatic int abs_int(input int x);
      return (x < 0) ? -x : x;
   endfunction

   // Ordered thresholds: the first rule that holds picks the class
   function automatic motion_class_type classify_motion(input int v, input int a, input int d);
      if (v < int'(STILL_SPEED) && d < int'(NEAR_CENTER)) return MC_BALANCED;
      if (v < int'(STILL_SPEED)) return MC_STILL_OFF;
      if (v > int'(ERRATIC_SPEED)) return MC_ERRATIC;
      if (a > int'(DECEL_ACCEL) && v > int'(DRIVE_SPEED)) return MC_DECELERATING;
      if (v > int'(OSC_SPEED_LO) && v < int'(OSC_SPEED_HI) && a > int'(OSC_ACCEL))
         return MC_OSCILLATING;
      if (v > int'(SMOOTH_SPEED) && a < v / 3) return MC_SMOOTH;
      if (v > int'(DRIVE_SPEED)) return MC_DRIVING;
      return MC_SLOW;
   endfunction

   task automatic note_mismatch(input string what, input int servo, input int want,
                                input int seen);
      failures++;
      if (failures <= REPORT_LIMIT)
         $display("%0t: %s on servo %0d: expected %0d, got %0d",
                  $time, what, servo, want, seen);
   endtask

   // Apply one accepted in-range sample to the shadow record and queue its result
   task automatic update_record(input req_type beat);
      logic [SERVO_IDX_W-1:0] id;
      logic [11:0]            pulse;
      logic [11:0]            old_center;
      int                     vel;
      int                     acc;
      motion_class_type       cls;
      rsp_type                want;
      if (beat.servo_index >= SERVO_COUNT) return;
      id         = beat.servo_index[SERVO_IDX_W-1:0];
      pulse      = beat.pulse_us;
      old_center = shadow_center[id];
      if (pulse < shadow_low[id]) shadow_low[id] = pulse;
      if (pulse > shadow_high[id]) shadow_high[id] = pulse;
      vel = int'(pulse) - int'(shadow_pulse[id]);
      acc = vel - int'(shadow_speed[id]);
      shadow_speed[id] = 12'(abs_int(vel));
      shadow_pulse[id] = pulse;
      cls = classify_motion(abs_int(vel), abs_int(acc),
                            abs_int(int'(pulse) - int'(old_center)));
      shadow_center[id] = 12'((int'(old_center) * 15) / 16 + int'(pulse) / 16);
      if (shadow_conf[id] != CONF_MAX) shadow_conf[id] = shadow_conf[id] + 8'd1;
      want.servo_echo        = beat.servo_index;
      want.motion_class      = cls;
      want.speed_us          = shadow_speed[id];
      want.learned_center    = shadow_center[id];
      want.lowest_seen       = shadow_low[id];
      want.highest_seen      = shadow_high[id];
      want.sample_confidence = shadow_conf[id];
      pending_updates.push_back(want);
   endtask

   // Compare a result beat with the oldest pending update
   task automatic check_update(input rsp_type seen);
      rsp_type want;
      if (pending_updates.size() == 0) begin
         note_mismatch("result beat with nothing pending", seen.servo_echo, 0, 1);
         return;
      end
      want = pending_updates.pop_front();
      if (seen.servo_echo !== want.servo_echo)
         note_mismatch("servo_echo", want.servo_echo, want.servo_echo, seen.servo_echo);
      if (seen.motion_class !== want.motion_class)
         note_mismatch("motion_class", want.servo_echo, want.motion_class,
                       seen.motion_class);
      if (seen.speed_us !== want.speed_us)
         note_mismatch("speed_us", want.servo_echo, want.speed_us, seen.speed_us);
      if (seen.learned_center !== want.learned_center)
         note_mismatch("learned_center", want.servo_echo, want.learned_center,
                       seen.learned_center);
      if (seen.lowest_seen !== want.lowest_seen)
         note_mismatch("lowest_seen", want.servo_echo, want.lowest_seen,
                       seen.lowest_seen);
      if (seen.highest_seen !== want.highest_seen)
         note_mismatch("highest_seen", want.servo_echo, want.highest_seen,
                       seen.highest_seen);
      if (seen.sample_confidence !== want.sample_confidence)
         note_mismatch("sample_confidence", want.servo_echo, want.sample_confidence,
                       seen.sample_confidence);
   endtask

   // Watch both channels; results are checked before new samples are applied
   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SERVO_COUNT; i++) begin
            shadow_pulse[i]  = 12'(CENTER_DEFAULT);
            shadow_speed[i]  = '0;
            shadow_center[i] = 12'(CENTER_DEFAULT);
            shadow_low[i]    = PULSE_MAX;
            shadow_high[i]   = '0;
            shadow_conf[i]   = '0;
         end
         pending_updates.delete();
         failures = 0;
         results_due <= 0;
      end else begin
         if (rsp_valid && rsp_ready) check_update(rsp_data);
         if (req_valid && req_ready) update_record(req_data);
         results_due <= pending_updates.size();
      end
   end

endmodule

`default_nettype wire

// ----- tb/servo_motion_observer_top_tb.sv -----
// Testbench top for the servo motion observer: clock, reset, sample stimulus,
// random result stalls and the verdict. Depends on smo_pkg, smo_checker and
// servo_motion_observer_top.
`default_nettype none

module servo_motion_observer_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import smo_pkg::*;

   localparam int RUN_LIMIT    = 200000;
   localparam int RANDOM_ITEMS = 350;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   int unsigned results_due;
   int unsigned failures;
   int unsigned cycle_count = 0;
   bit          no_idle     = 1'b0;

   int trail_pulse [SERVO_COUNT];
   int trail_step  [SERVO_COUNT];

   servo_motion_observer_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   smo_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .results_due (results_due),
      .failures    (failures)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= RUN_LIMIT) begin
         $display("servo_motion_observer_top_tb: FAIL");
         $finish;
      end
   end

   // Offer one sample beat after a random gap and hold it until taken
   task automatic send_sample(input logic [7:0] servo, input logic [11:0] pulse);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{servo_index: servo, pulse_us: pulse};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Drop valid and hold until every pending result has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (results_due != 0) @(posedge clock);
   endtask

   // Next pulse of a trajectory: jitter, steady sweep, moves of several sizes, jumps
   function automatic int next_pulse(input int last, input int step);
      int pick;
      int mag;
      int p;
      pick = $urandom_range(0, 99);
      if (pick < 10) return $urandom_range(0, 4095);
      if (pick < 30) begin
         p = last + step + int'($urandom_range(0, 4)) - 2;
      end else begin
         if (pick < 50)      mag = $urandom_range(0, 4);
         else if (pick < 80) mag = $urandom_range(5, 45);
         else if (pick < 95) mag = $urandom_range(46, 150);
         else                mag = $urandom_range(151, 600);
         if ($urandom_range(0, 1) == 0) mag = -mag;
         p = last + mag;
      end
      if (p < 0) p = 0;
      if (p > 4095) p = 4095;
      return p;
   endfunction

   // Result side: random stall before each beat
   initial begin : result_sink
      int stall;
      while (reset) @(posedge clock);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 8);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   initial begin : stimulus
      int          focus;
      int          sent;
      int          pick;
      int          servo;
      int          pulse;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extremes, every motion class, dropped servos
      send_sample(8'd0, 12'd0);        // far below center, erratic
      send_sample(8'd0, 12'd4095);     // full-scale jump
      send_sample(8'd0, 12'd4095);     // still, off center
      send_sample(8'd1, 12'd1500);     // still at center, balanced
      send_sample(8'd1, 12'd1502);
      send_sample(8'd1, 12'd1512);     // slow
      send_sample(8'd1, 12'd1532);
      send_sample(8'd1, 12'd1552);     // steady speed, smooth
      send_sample(8'd2, 12'd1600);     // sharp start, decelerating
      send_sample(8'd2, 12'd1801);     // erratic
      send_sample(8'd3, 12'd1530);     // oscillating
      send_sample(8'd4, 12'd1530);
      send_sample(8'd4, 12'd1590);     // driving
      send_sample(8'd15, 12'd2047);    // last servo
      send_sample(8'd16, 12'd1234);    // first id past the range, dropped
      send_sample(8'd255, 12'd4095);   // top id, dropped
      send_sample(8'd15, 12'd2048);
      send_sample(8'd15, 12'd2048);
      drain_results();

      for (int i = 0; i < SERVO_COUNT; i++) begin
         trail_pulse[i] = CENTER_DEFAULT;
         trail_step[i]  = 0;
      end

      // Random trajectories; one servo takes most beats so its confidence saturates
      focus = $urandom_range(0, SERVO_COUNT - 1);
      sent  = 0;
      while (sent < RANDOM_ITEMS) begin
         if (sent % 60 == 0) no_idle = ($urandom_range(0, 3) == 0);
         if (sent == RANDOM_ITEMS / 2) drain_results();
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            send_sample(8'($urandom_range(SERVO_COUNT, 255)), 12'($urandom_range(0, 4095)));
         end else begin
            servo = (pick < 85) ? focus : $urandom_range(0, SERVO_COUNT - 1);
            pulse = next_pulse(trail_pulse[servo], trail_step[servo]);
            trail_step[servo]  = pulse - trail_pulse[servo];
            trail_pulse[servo] = pulse;
            send_sample(8'(servo), 12'(pulse));
            sent++;
         end
      end
      no_idle = 1'b0;
      drain_results();
      repeat (10) @(posedge clock);

      if (failures == 0) begin
         $display("servo_motion_observer_top_tb: PASS");
      end else begin
         $display("servo_motion_observer_top_tb: FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ----- filelist.f -----
hdl/smo_pkg.sv
hdl/smo_motion_calc.sv
hdl/servo_motion_observer_top.sv
tb/smo_checker.sv
tb/servo_motion_observer_top_tb.sv
